// ----- hdl/ssp_pkg.sv -----
// Shared types, constants and register codes for the sprite screen projection block.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none
package ssp_pkg;

   // Screen geometry
   localparam int SCREEN_WIDTH  = 640;
   localparam int SCREEN_HEIGHT = 480;

   // Register indexes (byte address = 4 * index)
   localparam logic [2:0] REG_PLAYER_X       = 3'd0;
   localparam logic [2:0] REG_PLAYER_Y       = 3'd1;
   localparam logic [2:0] REG_VIEW_DIR_X     = 3'd2;
   localparam logic [2:0] REG_VIEW_DIR_Y     = 3'd3;
   localparam logic [2:0] REG_CAMERA_PLANE_X = 3'd4;
   localparam logic [2:0] REG_CAMERA_PLANE_Y = 3'd5;
   localparam logic [2:0] REG_HEIGHT_SCALE   = 3'd6;
   localparam logic [2:0] REG_WIDTH_DIVISOR  = 3'd7;
   localparam int ADDR_W = 5;

   // Divider geometry: numerator, divisor, quotient bits, remainder
   localparam int DIV_NW  = 66;
   localparam int DIV_DW  = 62;
   localparam int DIV_QW  = 41;
   localparam int DIV_RW  = DIV_DW + 1;
   localparam int DIV_HW  = DIV_NW - DIV_QW;
   localparam int DIV_LAT = DIV_QW + 1;

   // Derived datapath widths
   localparam int HNUM_W  = $clog2(SCREEN_HEIGHT + 1) + 31;
   localparam int WNUM_W  = $clog2(SCREEN_WIDTH + 1) + 32;
   localparam int CPROD_W = 42 + $clog2(SCREEN_WIDTH / 2 + 1) + 1;

   typedef struct packed {
      logic signed [31:0] player_x;
      logic signed [31:0] player_y;
      logic signed [31:0] view_dir_x;
      logic signed [31:0] view_dir_y;
      logic signed [31:0] camera_plane_x;
      logic signed [31:0] camera_plane_y;
      logic [30:0]        height_scale;
      logic [30:0]        width_divisor;
   } cfg_type;

   // Camera-space terms after the multiply stages
   typedef struct packed {
      logic               valid;
      logic signed [48:0] det;
      logic signed [49:0] numx;
      logic signed [49:0] numy;
   } front_type;

   // Sign and zero flags that ride alongside the first divider pair
   typedef struct packed {
      logic det_zero;
      logic sign_depth;
      logic sign_ratio;
   } side_a_type;

   // Terms handed to the second divider pair
   typedef struct packed {
      logic               valid;
      logic               vis;
      logic [30:0]        depth;
      logic signed [15:0] center;
      logic [HNUM_W-1:0]  hnum;
      logic [61:0]        wden;
   } mid_type;

   typedef struct packed {
      logic               vis;
      logic signed [15:0] center;
      logic [30:0]        depth;
   } side_b_type;

   typedef struct packed {
      logic               visible;
      logic signed [15:0] center_column;
      logic [14:0]        sprite_height;
      logic signed [15:0] top_row;
      logic signed [15:0] bottom_row;
      logic [14:0]        sprite_width;
      logic [14:0]        left_column;
      logic signed [15:0] right_column;
      logic signed [31:0] depth;
   } rsp_type;

endpackage
`default_nettype wire

// ----- hdl/ssp_csr.sv -----
// APB-style register bank holding the camera and scale settings.
// Depends on ssp_pkg for the register codes and the settings struct.
`default_nettype none
module ssp_csr (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [ssp_pkg::ADDR_W-1:0] paddr,
   input  wire logic [31:0]                pwdata,
   output logic      [31:0]                prdata,
   output logic                            pready,
   output ssp_pkg::cfg_type                cfg
);
   ssp_pkg::cfg_type cfg_ff, cfg_in;
   logic [2:0]       idx;

   assign idx    = paddr[4:2];
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   // write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         case (idx)
            ssp_pkg::REG_PLAYER_X:       cfg_in.player_x       = pwdata;
            ssp_pkg::REG_PLAYER_Y:       cfg_in.player_y       = pwdata;
            ssp_pkg::REG_VIEW_DIR_X:     cfg_in.view_dir_x     = pwdata;
            ssp_pkg::REG_VIEW_DIR_Y:     cfg_in.view_dir_y     = pwdata;
            ssp_pkg::REG_CAMERA_PLANE_X: cfg_in.camera_plane_x = pwdata;
            ssp_pkg::REG_CAMERA_PLANE_Y: cfg_in.camera_plane_y = pwdata;
            ssp_pkg::REG_HEIGHT_SCALE:   cfg_in.height_scale   = pwdata[30:0];
            ssp_pkg::REG_WIDTH_DIVISOR:  cfg_in.width_divisor  = pwdata[30:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.player_x       <= 32'sd0;
         cfg_ff.player_y       <= 32'sd0;
         cfg_ff.view_dir_x     <= 32'sd65536;
         cfg_ff.view_dir_y     <= 32'sd0;
         cfg_ff.camera_plane_x <= 32'sd0;
         cfg_ff.camera_plane_y <= 32'sd43253;
         cfg_ff.height_scale   <= 31'd65536;
         cfg_ff.width_divisor  <= 31'd65536;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      case (idx)
         ssp_pkg::REG_PLAYER_X:       prdata = cfg_ff.player_x;
         ssp_pkg::REG_PLAYER_Y:       prdata = cfg_ff.player_y;
         ssp_pkg::REG_VIEW_DIR_X:     prdata = cfg_ff.view_dir_x;
         ssp_pkg::REG_VIEW_DIR_Y:     prdata = cfg_ff.view_dir_y;
         ssp_pkg::REG_CAMERA_PLANE_X: prdata = cfg_ff.camera_plane_x;
         ssp_pkg::REG_CAMERA_PLANE_Y: prdata = cfg_ff.camera_plane_y;
         ssp_pkg::REG_HEIGHT_SCALE:   prdata = {1'b0, cfg_ff.height_scale};
         ssp_pkg::REG_WIDTH_DIVISOR:  prdata = {1'b0, cfg_ff.width_divisor};
         default:                     prdata = 32'd0;
      endcase
   end
endmodule
`default_nettype wire

// ----- hdl/ssp_front.sv -----
// Front stages: offset from the player, six registered products, floor shift and differences.
// Depends on ssp_pkg for the settings and front structs.
`default_nettype none
module ssp_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               in_valid,
   input  wire logic signed [31:0] sprite_world_x,
   input  wire logic signed [31:0] sprite_world_y,
   input  wire ssp_pkg::cfg_type   cfg,
   output ssp_pkg::front_type      s3
);
   logic               v1_ff, v2_ff, v3_ff;
   logic signed [32:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [63:0] pdet_a_ff, pdet_a_in, pdet_b_ff, pdet_b_in;
   logic signed [64:0] pnx_a_ff, pnx_a_in, pnx_b_ff, pnx_b_in;
   logic signed [64:0] pny_a_ff, pny_a_in, pny_b_ff, pny_b_in;
   logic signed [48:0] det_ff, det_in;
   logic signed [49:0] numx_ff, numx_in, numy_ff, numy_in;

   // stage 1: offsets
   assign dx_in = 33'(sprite_world_x) - 33'(cfg.player_x);
   assign dy_in = 33'(sprite_world_y) - 33'(cfg.player_y);

   // stage 2: products
   assign pdet_a_in = 64'(cfg.camera_plane_x) * 64'(cfg.view_dir_y);
   assign pdet_b_in = 64'(cfg.view_dir_x) * 64'(cfg.camera_plane_y);
   assign pnx_a_in  = 65'(cfg.view_dir_y) * 65'(dx_ff);
   assign pnx_b_in  = 65'(cfg.view_dir_x) * 65'(dy_ff);
   assign pny_a_in  = 65'(cfg.camera_plane_x) * 65'(dy_ff);
   assign pny_b_in  = 65'(cfg.camera_plane_y) * 65'(dx_ff);

   // stage 3: back to Q16.16, rounding down, then differences
   assign det_in  = 49'(pdet_a_ff >>> 16) - 49'(pdet_b_ff >>> 16);
   assign numx_in = 50'(pnx_a_ff >>> 16) - 50'(pnx_b_ff >>> 16);
   assign numy_in = 50'(pny_a_ff >>> 16) - 50'(pny_b_ff >>> 16);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff     <= dx_in;
         dy_ff     <= dy_in;
         pdet_a_ff <= pdet_a_in;
         pdet_b_ff <= pdet_b_in;
         pnx_a_ff  <= pnx_a_in;
         pnx_b_ff  <= pnx_b_in;
         pny_a_ff  <= pny_a_in;
         pny_b_ff  <= pny_b_in;
         det_ff    <= det_in;
         numx_ff   <= numx_in;
         numy_ff   <= numy_in;
      end
   end

   assign s3.valid = v3_ff;
   assign s3.det   = det_ff;
   assign s3.numx  = numx_ff;
   assign s3.numy  = numy_ff;
endmodule
`default_nettype wire

// ----- hdl/ssp_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Depends on ssp_pkg for its widths; the stages advance only while en is high.
`default_nettype none
module ssp_div (
   input  wire logic                       clock,
   input  wire logic                       en,
   input  wire logic [ssp_pkg::DIV_NW-1:0] num,
   input  wire logic [ssp_pkg::DIV_DW-1:0] den,
   output logic      [ssp_pkg::DIV_QW-1:0] quo,
   output logic                            ovf
);
   localparam int QW = ssp_pkg::DIV_QW;
   localparam int RW = ssp_pkg::DIV_RW;
   localparam int DW = ssp_pkg::DIV_DW;
   localparam int HW = ssp_pkg::DIV_HW;

   logic [RW-1:0] rem_ff [0:QW];
   logic [RW-1:0] rem_in [0:QW];
   logic [QW-1:0] lo_ff  [0:QW];
   logic [QW-1:0] lo_in  [0:QW];
   logic [QW-1:0] q_ff   [0:QW];
   logic [QW-1:0] q_in   [0:QW];
   logic [DW-1:0] den_ff [0:QW];
   logic          ovf_ff [0:QW];
   logic          ovf_in [0:QW];
   logic [RW-1:0] trial  [1:QW];

   // load: high part becomes the first remainder; quotient too big if it reaches the divisor
   always_comb begin
      rem_in[0] = RW'(num[ssp_pkg::DIV_NW-1:QW]);
      lo_in[0]  = num[QW-1:0];
      q_in[0]   = '0;
      ovf_in[0] = (RW'(num[ssp_pkg::DIV_NW-1:QW]) >= RW'(den));
      for (int k = 1; k <= QW; k++) begin
         trial[k]  = {rem_ff[k-1][RW-2:0], lo_ff[k-1][QW-1]};
         lo_in[k]  = {lo_ff[k-1][QW-2:0], 1'b0};
         ovf_in[k] = ovf_ff[k-1];
         if (trial[k] >= RW'(den_ff[k-1])) begin
            rem_in[k] = trial[k] - RW'(den_ff[k-1]);
            q_in[k]   = {q_ff[k-1][QW-2:0], 1'b1};
         end else begin
            rem_in[k] = trial[k];
            q_in[k]   = {q_ff[k-1][QW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff[0] <= den;
         for (int k = 0; k <= QW; k++) begin
            rem_ff[k] <= rem_in[k];
            lo_ff[k]  <= lo_in[k];
            q_ff[k]   <= q_in[k];
            ovf_ff[k] <= ovf_in[k];
         end
         for (int k = 1; k <= QW; k++) begin
            den_ff[k] <= den_ff[k-1];
         end
      end
   end

   assign quo = q_ff[QW];
   assign ovf = ovf_ff[QW] | (HW == 0);
endmodule
`default_nettype wire

// ----- hdl/ssp_mid.sv -----
// Middle stages: depth and ratio from the first quotients, then centre column and the
// operands of the height and width divisions. Depends on ssp_pkg.
`default_nettype none
module ssp_mid (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       en,
   input  wire logic                       in_valid,
   input  wire ssp_pkg::side_a_type        side,
   input  wire logic [ssp_pkg::DIV_QW-1:0] quo_depth,
   input  wire logic                       ovf_depth,
   input  wire logic [ssp_pkg::DIV_QW-1:0] quo_ratio,
   input  wire logic                       ovf_ratio,
   input  wire ssp_pkg::cfg_type           cfg,
   output ssp_pkg::mid_type                s6
);
   localparam int CW = ssp_pkg::CPROD_W;
   localparam logic [40:0] RATIO_CAP = 41'd1 << 40;

   logic               v5_ff, v6_ff;
   logic               vis5_ff, vis5_in, vis6_ff;
   logic [30:0]        depth5_ff, depth5_in, depth6_ff;
   logic signed [41:0] ratio5_ff, ratio5_in;
   logic [40:0]        rmag;
   logic signed [CW-1:0] cprod;
   logic signed [CW-1:0] cbias;
   logic signed [CW-17:0] ctr;
   logic signed [15:0] center_ff, center_in;
   logic [ssp_pkg::HNUM_W-1:0] hnum_ff, hnum_in;
   logic [61:0]        wden_ff, wden_in;

   // stage 5: visibility, saturated depth and ratio
   always_comb begin
      vis5_in   = !side.det_zero && !side.sign_depth && (ovf_depth || (quo_depth != '0));
      depth5_in = (ovf_depth || (quo_depth[40:31] != '0)) ? 31'h7fff_ffff : quo_depth[30:0];
      rmag      = (ovf_ratio || (quo_ratio > RATIO_CAP)) ? RATIO_CAP : quo_ratio;
      ratio5_in = side.sign_ratio ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
   end

   // stage 6: centre column (truncating divide by 65536), height and width operands
   always_comb begin
      cprod = CW'(ssp_pkg::SCREEN_WIDTH / 2) * (CW'(ratio5_ff) + CW'(65536));
      cbias = cprod[CW-1] ? (cprod + CW'(65535)) : cprod;
      ctr   = cbias[CW-1:16];
      if (ctr > (CW-16)'(32767)) begin
         center_in = 16'sh7fff;
      end else if (ctr < -(CW-16)'(32768)) begin
         center_in = -16'sh8000;
      end else begin
         center_in = ctr[15:0];
      end
      hnum_in = ssp_pkg::HNUM_W'(ssp_pkg::SCREEN_HEIGHT) * ssp_pkg::HNUM_W'(cfg.height_scale);
      wden_in = 62'(depth5_ff) * 62'(cfg.width_divisor);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= in_valid;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vis5_ff   <= vis5_in;
         depth5_ff <= depth5_in;
         ratio5_ff <= ratio5_in;
         vis6_ff   <= vis5_ff;
         depth6_ff <= depth5_ff;
         center_ff <= center_in;
         hnum_ff   <= hnum_in;
         wden_ff   <= wden_in;
      end
   end

   assign s6.valid  = v6_ff;
   assign s6.vis    = vis6_ff;
   assign s6.depth  = depth6_ff;
   assign s6.center = center_ff;
   assign s6.hnum   = hnum_ff;
   assign s6.wden   = wden_ff;
endmodule
`default_nettype wire

// ----- hdl/ssp_back.sv -----
// Final formatting: height and width saturation, row and column spans, zeroing when hidden.
// Depends on ssp_pkg for the result struct and screen constants.
`default_nettype none
module ssp_back (
   input  wire ssp_pkg::side_b_type        side,
   input  wire logic [ssp_pkg::DIV_QW-1:0] quo_h,
   input  wire logic                       ovf_h,
   input  wire logic [ssp_pkg::DIV_QW-1:0] quo_w,
   input  wire logic                       ovf_w,
   output ssp_pkg::rsp_type                rsp
);
   logic [14:0]        h, w;
   logic signed [16:0] left_c, right_c;

   always_comb begin
      h = (ovf_h || (quo_h[40:15] != '0)) ? 15'h7fff : quo_h[14:0];
      w = (ovf_w || (quo_w[40:15] != '0)) ? 15'h7fff : quo_w[14:0];
      left_c  = 17'(side.center) - $signed({3'b000, w[14:1]});
      right_c = 17'(side.center) + $signed({3'b000, w[14:1]});
      rsp = '0;
      if (side.vis) begin
         rsp.visible       = 1'b1;
         rsp.center_column = side.center;
         rsp.sprite_height = h;
         rsp.top_row       = 16'(ssp_pkg::SCREEN_HEIGHT / 2) - $signed({2'b00, h[14:1]});
         rsp.bottom_row    = 16'(ssp_pkg::SCREEN_HEIGHT / 2) + $signed({2'b00, h[14:1]});
         rsp.sprite_width  = w;
         rsp.left_column   = left_c[16] ? 15'd0 : left_c[14:0];
         rsp.right_column  = (right_c >= 17'(ssp_pkg::SCREEN_WIDTH)) ?
                             16'(ssp_pkg::SCREEN_WIDTH) : right_c[15:0];
         rsp.depth         = $signed({1'b0, side.depth});
      end
   end
endmodule
`default_nettype wire

// ----- hdl/sprite_screen_projection.sv -----
// Top level of the sprite screen projection pipeline: register bank, front stages,
// two divider pairs with side lines, middle and back stages. Depends on ssp_pkg and all ssp_ modules.
//
//   Channel   Ports                         Direction  Transaction
//   req       req_valid/req_ready, world xy in         one sprite position
//   rsp       rsp_valid/rsp_ready, 9 fields out        one projection result
//   csr       psel..prdata, pready=1        in/out     one register access
//
// One sprite enters every cycle unless the pipeline holds; each passes the front stages, the
// first divider pair, the middle stages, the second divider pair and the output register.
// Reset is synchronous; it clears the valid bits and loads the register bank with its defaults.
// The pipeline moves as a whole; it holds only when the output register is full, not
// taken, and a result waits in the last stage, so bubbles drain while the output waits.
`default_nettype none
module sprite_screen_projection (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic signed [31:0]         req_sprite_world_x,
   input  wire logic signed [31:0]         req_sprite_world_y,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic                            rsp_visible,
   output logic signed [15:0]              rsp_center_column,
   output logic [14:0]                     rsp_sprite_height,
   output logic signed [15:0]              rsp_top_row,
   output logic signed [15:0]              rsp_bottom_row,
   output logic [14:0]                     rsp_sprite_width,
   output logic [14:0]                     rsp_left_column,
   output logic signed [15:0]              rsp_right_column,
   output logic signed [31:0]              rsp_depth,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [ssp_pkg::ADDR_W-1:0] paddr,
   input  wire logic [31:0]                pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   localparam int LAT = ssp_pkg::DIV_LAT;

   ssp_pkg::cfg_type    cfg;
   ssp_pkg::front_type  s3;
   ssp_pkg::mid_type    s6;
   ssp_pkg::side_a_type side_a_in;
   ssp_pkg::side_a_type side_a_ff [0:LAT-1];
   ssp_pkg::side_b_type side_b_in;
   ssp_pkg::side_b_type side_b_ff [0:LAT-1];
   ssp_pkg::rsp_type    rsp_in, rsp_ff;
   logic                va_ff [0:LAT-1];
   logic                vb_ff [0:LAT-1];
   logic                rsp_valid_ff;
   logic                en;

   logic [49:0] mag_numx, mag_numy;
   logic [48:0] mag_det;
   logic [ssp_pkg::DIV_NW-1:0] num_depth, num_ratio, num_h, num_w;
   logic [ssp_pkg::DIV_DW-1:0] den_depth, den_ratio, den_h, den_w;
   logic [ssp_pkg::DIV_QW-1:0] quo_depth, quo_ratio, quo_h, quo_w;
   logic ovf_depth, ovf_ratio, ovf_h, ovf_w;

   // advance unless a finished result would be overwritten
   assign en        = !rsp_valid_ff || rsp_ready || !vb_ff[LAT-1];
   assign req_ready = en;

   ssp_csr u_csr (
      .clock, .reset, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
   );

   ssp_front u_front (
      .clock, .reset, .en,
      .in_valid       (req_valid),
      .sprite_world_x (req_sprite_world_x),
      .sprite_world_y (req_sprite_world_y),
      .cfg, .s3
   );

   // first division pair: depth and lateral ratio, on magnitudes
   always_comb begin
      mag_numx  = s3.numx[49] ? 50'(-s3.numx) : 50'(s3.numx);
      mag_numy  = s3.numy[49] ? 50'(-s3.numy) : 50'(s3.numy);
      mag_det   = s3.det[48]  ? 49'(-s3.det)  : 49'(s3.det);
      num_depth = {mag_numy, 16'd0};
      den_depth = ssp_pkg::DIV_DW'(mag_det);
      num_ratio = {mag_numx, 16'd0};
      den_ratio = ssp_pkg::DIV_DW'(mag_numy);
      side_a_in.det_zero   = (s3.det == '0);
      side_a_in.sign_depth = s3.numy[49] ^ s3.det[48];
      side_a_in.sign_ratio = s3.numx[49] ^ s3.numy[49];
   end

   ssp_div u_div_depth (
      .clock, .en, .num (num_depth), .den (den_depth), .quo (quo_depth), .ovf (ovf_depth)
   );
   ssp_div u_div_ratio (
      .clock, .en, .num (num_ratio), .den (den_ratio), .quo (quo_ratio), .ovf (ovf_ratio)
   );

   ssp_mid u_mid (
      .clock, .reset, .en,
      .in_valid (va_ff[LAT-1]),
      .side     (side_a_ff[LAT-1]),
      .quo_depth, .ovf_depth, .quo_ratio, .ovf_ratio, .cfg, .s6
   );

   // second division pair: height and width
   always_comb begin
      num_h = ssp_pkg::DIV_NW'(s6.hnum);
      den_h = ssp_pkg::DIV_DW'(s6.depth);
      num_w = ssp_pkg::DIV_NW'(ssp_pkg::WNUM_W'(ssp_pkg::SCREEN_WIDTH) << 32);
      den_w = s6.wden;
      side_b_in.vis    = s6.vis;
      side_b_in.center = s6.center;
      side_b_in.depth  = s6.depth;
   end

   ssp_div u_div_h (
      .clock, .en, .num (num_h), .den (den_h), .quo (quo_h), .ovf (ovf_h)
   );
   ssp_div u_div_w (
      .clock, .en, .num (num_w), .den (den_w), .quo (quo_w), .ovf (ovf_w)
   );

   ssp_back u_back (
      .side (side_b_ff[LAT-1]), .quo_h, .ovf_h, .quo_w, .ovf_w, .rsp (rsp_in)
   );

   // side lines alongside the dividers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) begin
            va_ff[k] <= 1'b0;
            vb_ff[k] <= 1'b0;
         end
      end else if (en) begin
         va_ff[0] <= s3.valid;
         vb_ff[0] <= s6.valid;
         for (int k = 1; k < LAT; k++) begin
            va_ff[k] <= va_ff[k-1];
            vb_ff[k] <= vb_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_a_ff[0] <= side_a_in;
         side_b_ff[0] <= side_b_in;
         for (int k = 1; k < LAT; k++) begin
            side_a_ff[k] <= side_a_ff[k-1];
            side_b_ff[k] <= side_b_ff[k-1];
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vb_ff[LAT-1] || (rsp_valid_ff && !rsp_ready);
      end
   end

   always_ff @(posedge clock) begin
      if (en && vb_ff[LAT-1]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_visible       = rsp_ff.visible;
   assign rsp_center_column = rsp_ff.center_column;
   assign rsp_sprite_height = rsp_ff.sprite_height;
   assign rsp_top_row       = rsp_ff.top_row;
   assign rsp_bottom_row    = rsp_ff.bottom_row;
   assign rsp_sprite_width  = rsp_ff.sprite_width;
   assign rsp_left_column   = rsp_ff.left_column;
   assign rsp_right_column  = rsp_ff.right_column;
   assign rsp_depth         = rsp_ff.depth;
endmodule
`default_nettype wire
